>>> rtl/unpm_pkg.sv
`default_nettype none

package unpm_pkg;

   localparam int ChanW    = 16;
   localparam int OutW     = 8;
   localparam int NumLanes = 3;
   // One division cell per result bit.
   localparam int NumCells = OutW;

   localparam logic [OutW-1:0] OutMax = '1;

   typedef struct packed {
      logic [ChanW-1:0] rem;
      logic [OutW-1:0]  low;
      logic [OutW-1:0]  quo;
      logic             sat;
   } unpm_lane_type;

   typedef struct packed {
      unpm_lane_type [NumLanes-1:0] lane;
      logic [ChanW-1:0]             divisor;
      logic [OutW-1:0]              alpha_hi;
      logic                         zero;
   } unpm_stage_type;

endpackage

`default_nettype wire

>>> rtl/unpm_req_if.sv
`default_nettype none

interface unpm_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] red_in;
   logic [15:0] green_in;
   logic [15:0] blue_in;
   logic [15:0] alpha_in;

   modport source (output valid, red_in, green_in, blue_in, alpha_in, input ready);
   modport sink (input valid, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

`default_nettype wire

>>> rtl/unpm_rsp_if.sv
`default_nettype none

interface unpm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic [7:0] alpha_out;

   modport source (output valid, red_out, green_out, blue_out, alpha_out, input ready);
   modport sink (input valid, red_out, green_out, blue_out, alpha_out, output ready);
endinterface

`default_nettype wire

>>> rtl/rgba16_premul_to_rgba8_straight.sv
`default_nettype none

// Converts one 16-bit premultiplied RGBA pixel per word into an 8-bit
// straight-alpha RGBA word: each color becomes min(c*65535/a, 65535) >> 8,
// colors are zero when alpha is zero, and alpha passes as its top byte.
// A new word is accepted every clock cycle while the result side does not
// push back. The pipeline holds one setup stage, a row of eight
// restoring-division cells that each produce one quotient bit for all three
// colors, and the output register. Stalls on the result side fill bubbles in
// the row before they push back on the request side. There is no
// configuration and no state beyond the pipeline.
module rgba16_premul_to_rgba8_straight
   import unpm_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   unpm_req_if.sink  req_ch,
   unpm_rsp_if.source rsp_ch
);

   logic           chain_valid [NumCells+1];
   logic           chain_ready [NumCells+1];
   unpm_stage_type chain_data  [NumCells+1];

   logic            out_valid_ff;
   logic            out_valid_in;
   logic            out_load;
   logic [OutW-1:0] color_in [NumLanes];
   logic [OutW-1:0] red_ff;
   logic [OutW-1:0] green_ff;
   logic [OutW-1:0] blue_ff;
   logic [OutW-1:0] alpha_ff;

   unpm_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .out_valid (chain_valid[0]),
      .out_ready (chain_ready[0]),
      .out_data  (chain_data[0])
   );

   for (genvar k = 0; k < NumCells; k++) begin : g_cell
      unpm_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   assign chain_ready[NumCells] = !out_valid_ff || rsp_ch.ready;

   always_comb begin
      out_load     = chain_valid[NumCells] && chain_ready[NumCells];
      out_valid_in = chain_ready[NumCells] ? chain_valid[NumCells] : out_valid_ff;
      for (int i = 0; i < NumLanes; i++) begin
         if (chain_data[NumCells].zero) begin
            color_in[i] = '0;
         end else if (chain_data[NumCells].lane[i].sat) begin
            color_in[i] = OutMax;
         end else begin
            color_in[i] = chain_data[NumCells].lane[i].quo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (out_load) begin
         red_ff   <= color_in[0];
         green_ff <= color_in[1];
         blue_ff  <= color_in[2];
         alpha_ff <= chain_data[NumCells].alpha_hi;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.red_out   = red_ff;
   assign rsp_ch.green_out = green_ff;
   assign rsp_ch.blue_out  = blue_ff;
   assign rsp_ch.alpha_out = alpha_ff;

   // An accepted word always lands in the setup stage.
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> chain_valid[0])
      else $error("accepted word did not enter the setup stage");

   // Zero alpha is always routed through the saturated path.
   assert property (@(posedge clock) disable iff (reset)
      chain_valid[NumCells] && chain_data[NumCells].zero |->
         chain_data[NumCells].lane[0].sat && chain_data[NumCells].lane[1].sat &&
         chain_data[NumCells].lane[2].sat)
      else $error("zero alpha reached the end of the row unsaturated");

   // A finished unsaturated division leaves a remainder below the divisor.
   assert property (@(posedge clock) disable iff (reset)
      chain_valid[NumCells] && !chain_data[NumCells].zero |->
         (chain_data[NumCells].lane[0].sat ||
          chain_data[NumCells].lane[0].rem < chain_data[NumCells].divisor) &&
         (chain_data[NumCells].lane[1].sat ||
          chain_data[NumCells].lane[1].rem < chain_data[NumCells].divisor) &&
         (chain_data[NumCells].lane[2].sat ||
          chain_data[NumCells].lane[2].rem < chain_data[NumCells].divisor))
      else $error("division remainder out of range");

endmodule

`default_nettype wire

>>> rtl/unpm_prep.sv
`default_nettype none

module unpm_prep
   import unpm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   unpm_req_if.sink            req_ch,
   output logic                out_valid,
   input  wire logic           out_ready,
   output unpm_stage_type      out_data
);

   logic           valid_ff;
   logic           valid_in;
   logic           load;
   unpm_stage_type data_ff;
   unpm_stage_type data_in;
   logic [ChanW-1:0]   color [NumLanes];
   logic [2*ChanW-1:0] prod  [NumLanes];

   assign color[0] = req_ch.red_in;
   assign color[1] = req_ch.green_in;
   assign color[2] = req_ch.blue_in;

   always_comb begin
      req_ch.ready = !valid_ff || out_ready;
      load         = req_ch.valid && req_ch.ready;
      valid_in     = req_ch.ready ? req_ch.valid : valid_ff;

      data_in.divisor  = req_ch.alpha_in;
      data_in.alpha_hi = req_ch.alpha_in[ChanW-1 -: OutW];
      data_in.zero     = (req_ch.alpha_in == '0);
      for (int i = 0; i < NumLanes; i++) begin
         // c * 0xFFFF written as (c << 16) - c.
         prod[i] = {color[i], {ChanW{1'b0}}} - {{ChanW{1'b0}}, color[i]};
         // A color at or above alpha saturates; above alpha the division would overflow.
         data_in.lane[i].sat = (color[i] >= req_ch.alpha_in);
         data_in.lane[i].rem = data_in.lane[i].sat ? '0 : prod[i][2*ChanW-1:ChanW];
         data_in.lane[i].low = prod[i][ChanW-1 -: OutW];
         data_in.lane[i].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

>>> rtl/unpm_div_cell.sv
`default_nettype none

module unpm_div_cell
   import unpm_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire unpm_stage_type in_data,
   output logic                out_valid,
   input  wire logic           out_ready,
   output unpm_stage_type      out_data
);

   logic           valid_ff;
   logic           valid_in;
   logic           load;
   unpm_stage_type data_ff;
   unpm_stage_type data_in;
   logic [ChanW:0] trial [NumLanes];
   logic [ChanW:0] diff  [NumLanes];
   logic           ge    [NumLanes];

   // One restoring division step per lane: bring down the next dividend bit,
   // subtract the divisor when it fits, and shift in one quotient bit.
   always_comb begin
      in_ready = !valid_ff || out_ready;
      load     = in_valid && in_ready;
      valid_in = in_ready ? in_valid : valid_ff;

      data_in = in_data;
      for (int i = 0; i < NumLanes; i++) begin
         trial[i] = {in_data.lane[i].rem, in_data.lane[i].low[OutW-1]};
         diff[i]  = trial[i] - {1'b0, in_data.divisor};
         ge[i]    = (trial[i] >= {1'b0, in_data.divisor});
         data_in.lane[i].rem = ge[i] ? diff[i][ChanW-1:0] : trial[i][ChanW-1:0];
         data_in.lane[i].low = {in_data.lane[i].low[OutW-2:0], 1'b0};
         data_in.lane[i].quo = {in_data.lane[i].quo[OutW-2:0], ge[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire
